[src/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent property on the block clock, off while reset is held.
`define ASSERT_PROP(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Condition that must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(label, cond, msg) \
    `ASSERT_PROP(label, (1'b1 |-> (cond)), msg)

`endif

[src/tod_pkg.sv]
// Package: commands, constants and shared types of the time-of-day unit.
package tod_pkg;

    localparam int IN_TDATA_W  = 72;
    localparam int IN_TUSER_W  = 3;
    localparam int OUT_TDATA_W = 40;
    localparam int OUT_TUSER_W = 1;

    typedef enum logic [2:0] {
        CMD_VALIDATE     = 3'd0,
        CMD_TO_SECONDS   = 3'd1,
        CMD_FROM_SECONDS = 3'd2,
        CMD_COMPARE      = 3'd3,
        CMD_ADD          = 3'd4,
        CMD_SUBTRACT     = 3'd5,
        CMD_DURATION     = 3'd6
    } t_cmd;

    localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
    localparam logic [16:0] SECS_PER_HOUR = 17'd3600;
    localparam logic [16:0] SECS_PER_MIN  = 17'd60;
    localparam logic [4:0]  MAX_HOUR      = 5'd23;
    localparam logic [5:0]  MAX_MINSEC    = 6'd59;

    // 86400 = 128 * 675: low 7 bits pass, upper part reduced mod 675.
    localparam logic [9:0]  DIV_675    = 10'd675;
    // 675 * 24856, lifts the arithmetic-shifted upper part above zero.
    localparam logic [26:0] RED_OFFSET = 27'd16777800;
    // floor(2^36 / 675), floor(2^28 / 3600), floor(2^18 / 60)
    localparam logic [26:0] RCP_675    = 27'd101806632;
    localparam logic [16:0] RCP_HOUR   = 17'd74565;
    localparam logic [12:0] RCP_MIN    = 13'd4369;

    // Result fields that ride alongside the reduction pipeline.
    typedef struct packed {
        logic        ok;        // valid_res
        logic        use_time;  // take H:M:S and total from the reducer
        logic [16:0] sec_total; // to_seconds / duration result
        logic        eq;
        logic        lt;
        logic        gt;
    } t_side;

endpackage

[src/tod_front.sv]
// Front stages: operand unpack, validation, H:M:S to seconds, compare, sum.
module tod_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic                            i_vld,
    input  logic [tod_pkg::IN_TUSER_W-1:0]  i_cmd,
    input  logic [tod_pkg::IN_TDATA_W-1:0]  i_data,
    output logic                            o_vld,
    output logic [25:0]                     o_q,
    output logic [6:0]                      o_low,
    output tod_pkg::t_side                  o_side
);
    import tod_pkg::*;

    logic [4:0]  w_ha, w_hb;
    logic [5:0]  w_ma, w_sa, w_mb, w_sb;
    logic [31:0] n_a_amt, r_a_amt;
    logic [16:0] n_a_ta, n_a_tb, r_a_ta, r_a_tb;
    logic        n_a_va, n_a_vb, r_a_va, r_a_vb, r_a_vld;
    t_cmd        r_a_cmd;

    logic [33:0] w_ta_x, w_amt_x, w_x;
    logic [26:0] w_qs;
    t_side       n_b_side, r_b_side;
    logic [25:0] r_b_q;
    logic [6:0]  r_b_low;
    logic        r_b_vld;

    assign w_ha    = i_data[4:0];
    assign w_ma    = i_data[10:5];
    assign w_sa    = i_data[16:11];
    assign w_hb    = i_data[21:17];
    assign w_mb    = i_data[27:22];
    assign w_sb    = i_data[33:28];
    assign n_a_amt = i_data[65:34];

    assign n_a_va = (w_ha <= MAX_HOUR) && (w_ma <= MAX_MINSEC) && (w_sa <= MAX_MINSEC);
    assign n_a_vb = (w_hb <= MAX_HOUR) && (w_mb <= MAX_MINSEC) && (w_sb <= MAX_MINSEC);
    assign n_a_ta = 17'(w_ha) * SECS_PER_HOUR + 17'(w_ma) * SECS_PER_MIN + 17'(w_sa);
    assign n_a_tb = 17'(w_hb) * SECS_PER_HOUR + 17'(w_mb) * SECS_PER_MIN + 17'(w_sb);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (i_en) begin
            r_a_vld <= i_vld;
        end
        if (i_en) begin
            r_a_cmd <= t_cmd'(i_cmd);
            r_a_va  <= n_a_va;
            r_a_vb  <= n_a_vb;
            r_a_ta  <= n_a_ta;
            r_a_tb  <= n_a_tb;
            r_a_amt <= n_a_amt;
        end
    end

    // signed 34-bit sum, then split as 128 * upper + low7
    assign w_ta_x  = {17'b0, r_a_ta};
    assign w_amt_x = {{2{r_a_amt[31]}}, r_a_amt};

    always_comb begin
        n_b_side = '0;
        w_x      = w_ta_x + w_amt_x;
        unique case (r_a_cmd)
            CMD_VALIDATE: begin
                n_b_side.ok = r_a_va;
            end
            CMD_TO_SECONDS: begin
                n_b_side.ok        = r_a_va;
                n_b_side.sec_total = r_a_va ? r_a_ta : 17'd0;
            end
            CMD_FROM_SECONDS: begin
                w_x               = w_amt_x;
                n_b_side.ok       = 1'b1;
                n_b_side.use_time = 1'b1;
            end
            CMD_COMPARE: begin
                if (r_a_va && r_a_vb) begin
                    n_b_side.ok = 1'b1;
                    n_b_side.eq = (r_a_ta == r_a_tb);
                    n_b_side.lt = (r_a_ta < r_a_tb);
                    n_b_side.gt = (r_a_ta > r_a_tb);
                end
            end
            CMD_ADD: begin
                n_b_side.ok       = r_a_va;
                n_b_side.use_time = r_a_va;
            end
            CMD_SUBTRACT: begin
                w_x               = w_ta_x - w_amt_x;
                n_b_side.ok       = r_a_va;
                n_b_side.use_time = r_a_va;
            end
            CMD_DURATION: begin
                if (r_a_va && r_a_vb) begin
                    n_b_side.ok        = 1'b1;
                    n_b_side.sec_total = (r_a_ta > r_a_tb)
                                       ? r_a_tb - r_a_ta + SECS_PER_DAY
                                       : r_a_tb - r_a_ta;
                end
            end
            default: begin
                n_b_side = '0;
            end
        endcase
    end

    // shifted upper part plus offset is non-negative and below 2^26
    assign w_qs = w_x[33:7] + RED_OFFSET;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (i_en) begin
            r_b_vld <= r_a_vld;
        end
        if (i_en) begin
            r_b_q    <= w_qs[25:0];
            r_b_low  <= w_x[6:0];
            r_b_side <= n_b_side;
        end
    end

    assign o_vld  = r_b_vld;
    assign o_q    = r_b_q;
    assign o_low  = r_b_low;
    assign o_side = r_b_side;

endmodule

[src/tod_reduce.sv]
// Reduction stages: seconds value modulo 86400 by reciprocal multiply.
module tod_reduce (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_vld,
    input  logic [25:0]     i_q,
    input  logic [6:0]      i_low,
    input  tod_pkg::t_side  i_side,
    output logic            o_vld,
    output logic [16:0]     o_t,
    output tod_pkg::t_side  o_side
);
    import tod_pkg::*;

    logic [52:0] w_prod;
    logic [25:0] w_diff;
    logic [10:0] w_fix;

    logic [16:0] r_c_qq;
    logic [25:0] r_c_q;
    logic [6:0]  r_c_low, r_d_low;
    t_side       r_c_side, r_d_side, r_e_side;
    logic [10:0] r_d_rem;
    logic [16:0] r_e_t;
    logic        r_c_vld, r_d_vld, r_e_vld;

    // quotient estimate, low by at most one
    assign w_prod = 53'(i_q) * 53'(RCP_675);
    assign w_diff = r_c_q - 26'(r_c_qq) * 26'(DIV_675);
    assign w_fix  = (r_d_rem >= 11'(DIV_675)) ? r_d_rem - 11'(DIV_675) : r_d_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
            r_e_vld <= 1'b0;
        end else if (i_en) begin
            r_c_vld <= i_vld;
            r_d_vld <= r_c_vld;
            r_e_vld <= r_d_vld;
        end
        if (i_en) begin
            r_c_qq   <= w_prod[52:36];
            r_c_q    <= i_q;
            r_c_low  <= i_low;
            r_c_side <= i_side;
            r_d_rem  <= w_diff[10:0];
            r_d_low  <= r_c_low;
            r_d_side <= r_c_side;
            r_e_t    <= {w_fix[9:0], r_d_low};
            r_e_side <= r_d_side;
        end
    end

    assign o_vld  = r_e_vld;
    assign o_t    = r_e_t;
    assign o_side = r_e_side;

endmodule

[src/tod_split.sv]
// Split stages: seconds of day to hour and seconds within hour, minute estimate.
module tod_split (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_vld,
    input  logic [16:0]     i_t,
    input  tod_pkg::t_side  i_side,
    output logic            o_vld,
    output logic [16:0]     o_t,
    output logic [4:0]      o_hour,
    output logic [11:0]     o_rem,
    output logic [5:0]      o_mq,
    output tod_pkg::t_side  o_side
);
    import tod_pkg::*;

    logic [33:0] w_hp;
    logic [16:0] w_hd;
    logic [24:0] w_mp;
    logic [4:0]  n_g_h;
    logic [16:0] n_g_rem;

    logic [4:0]  r_f_hq, r_g_h, r_h_h;
    logic [16:0] r_f_t, r_g_t, r_h_t;
    logic [11:0] r_g_rem, r_h_rem;
    logic [5:0]  r_h_mq;
    t_side       r_f_side, r_g_side, r_h_side;
    logic        r_f_vld, r_g_vld, r_h_vld;

    assign w_hp = 34'(i_t) * 34'(RCP_HOUR);
    assign w_hd = r_f_t - 17'(r_f_hq) * SECS_PER_HOUR;

    always_comb begin
        if (w_hd >= SECS_PER_HOUR) begin
            n_g_h   = r_f_hq + 5'd1;
            n_g_rem = w_hd - SECS_PER_HOUR;
        end else begin
            n_g_h   = r_f_hq;
            n_g_rem = w_hd;
        end
    end

    assign w_mp = 25'(r_g_rem) * 25'(RCP_MIN);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_vld <= 1'b0;
            r_g_vld <= 1'b0;
            r_h_vld <= 1'b0;
        end else if (i_en) begin
            r_f_vld <= i_vld;
            r_g_vld <= r_f_vld;
            r_h_vld <= r_g_vld;
        end
        if (i_en) begin
            r_f_hq   <= w_hp[32:28];
            r_f_t    <= i_t;
            r_f_side <= i_side;
            r_g_h    <= n_g_h;
            r_g_rem  <= n_g_rem[11:0];
            r_g_t    <= r_f_t;
            r_g_side <= r_f_side;
            r_h_mq   <= w_mp[23:18];
            r_h_h    <= r_g_h;
            r_h_rem  <= r_g_rem;
            r_h_t    <= r_g_t;
            r_h_side <= r_g_side;
        end
    end

    assign o_vld  = r_h_vld;
    assign o_t    = r_h_t;
    assign o_hour = r_h_h;
    assign o_rem  = r_h_rem;
    assign o_mq   = r_h_mq;
    assign o_side = r_h_side;

endmodule

[src/time_of_day_arithmetic_unit.sv]
// Top level: time-of-day unit, nine-stage pipeline with stream ports.
// Path: front, reduce and split stages, then the output register.
// Throughput: one beat per cycle unless output stalls; every stage ends in
// a register; the mod-86400 and H:M:S splits use reciprocals.
// Stall: the whole pipe holds while the output beat waits, s_axis_tready low.
// Reset: synchronous active-low i_rst_n clears all stage valid bits.
module time_of_day_arithmetic_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // hour_a[4:0] minute_a[10:5] second_a[16:11] hour_b[21:17]
    // minute_b[27:22] second_b[33:28] amount[65:34] zero pad[71:66]
    input  logic [tod_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // command[2:0]
    input  logic [tod_pkg::IN_TUSER_W-1:0]   s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // hour[4:0] minute[10:5] second[16:11] seconds_total[33:17]
    // equal[34] less[35] greater[36] zero pad[39:37]
    output logic [tod_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    // valid_res[0]
    output logic [tod_pkg::OUT_TUSER_W-1:0]  m_axis_tuser
);
    import tod_pkg::*;

    // single pipe enable: move unless the output beat is stuck
    logic        w_en;

    logic        w_b_vld, w_e_vld, w_h_vld;
    logic [25:0] w_b_q;
    logic [6:0]  w_b_low;
    logic [16:0] w_e_t, w_h_t;
    logic [4:0]  w_h_hour;
    logic [11:0] w_h_rem;
    logic [5:0]  w_h_mq;
    t_side       w_b_side, w_e_side, w_h_side;

    logic [11:0] w_mdiff;
    logic [5:0]  w_min, w_sec;
    logic [OUT_TDATA_W-1:0] n_tdata, r_tdata;
    logic        r_vld, r_ok;

    assign w_en          = !r_vld || m_axis_tready;
    assign s_axis_tready = w_en;

    tod_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (s_axis_tvalid),
        .i_cmd   (s_axis_tuser),
        .i_data  (s_axis_tdata),
        .o_vld   (w_b_vld),
        .o_q     (w_b_q),
        .o_low   (w_b_low),
        .o_side  (w_b_side)
    );

    tod_reduce u_reduce (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_b_vld),
        .i_q     (w_b_q),
        .i_low   (w_b_low),
        .i_side  (w_b_side),
        .o_vld   (w_e_vld),
        .o_t     (w_e_t),
        .o_side  (w_e_side)
    );

    tod_split u_split (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_e_vld),
        .i_t     (w_e_t),
        .i_side  (w_e_side),
        .o_vld   (w_h_vld),
        .o_t     (w_h_t),
        .o_hour  (w_h_hour),
        .o_rem   (w_h_rem),
        .o_mq    (w_h_mq),
        .o_side  (w_h_side)
    );

    // last split step: minute estimate may be one low
    assign w_mdiff = w_h_rem - 12'(w_h_mq) * 12'(SECS_PER_MIN);

    always_comb begin
        if (w_mdiff >= 12'(SECS_PER_MIN)) begin
            w_min = w_h_mq + 6'd1;
            w_sec = 6'(w_mdiff - 12'(SECS_PER_MIN));
        end else begin
            w_min = w_h_mq;
            w_sec = w_mdiff[5:0];
        end
    end

    // pack result; fields a command does not name are zero
    always_comb begin
        n_tdata = '0;
        if (w_h_side.use_time) begin
            n_tdata[4:0]   = w_h_hour;
            n_tdata[10:5]  = w_min;
            n_tdata[16:11] = w_sec;
            n_tdata[33:17] = w_h_t;
        end else begin
            n_tdata[33:17] = w_h_side.sec_total;
        end
        n_tdata[34] = w_h_side.eq;
        n_tdata[35] = w_h_side.lt;
        n_tdata[36] = w_h_side.gt;
    end

    // output register, holds while the consumer stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (w_en) begin
            r_vld <= w_h_vld;
        end
        if (w_en) begin
            r_tdata <= n_tdata;
            r_ok    <= w_h_side.ok;
        end
    end

    assign m_axis_tvalid = r_vld;
    assign m_axis_tdata  = r_tdata;
    assign m_axis_tuser  = r_ok;

endmodule

[src/tod_checker.sv]
// Port-level checker for the time-of-day unit, bound to the top level.
`include "assert_macros.svh"

module tod_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic [tod_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    input logic [tod_pkg::IN_TUSER_W-1:0]   s_axis_tuser,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [tod_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    input logic [tod_pkg::OUT_TUSER_W-1:0]  m_axis_tuser
);
    import tod_pkg::*;

    // stalled output beat holds
    `ASSERT_PROP(a_out_hold, (m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)), "output beat changed under stall")

    // input side is open whenever the output register is empty
    `ASSERT_PROP(a_ready_when_empty, (!m_axis_tvalid |-> s_axis_tready), "ready low with empty output")

    // invalid operands give an all-zero result
    `ASSERT_PROP(a_invalid_zero, (m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0), "nonzero result with valid_res low")

    // result time and total stay inside one day
    `ASSERT_ALWAYS(a_time_range, (!m_axis_tvalid || (m_axis_tdata[4:0] <= MAX_HOUR && m_axis_tdata[10:5] <= MAX_MINSEC && m_axis_tdata[16:11] <= MAX_MINSEC && m_axis_tdata[33:17] < SECS_PER_DAY)), "result outside day range")

    // at most one compare flag
    `ASSERT_ALWAYS(a_cmp_flags, (!m_axis_tvalid || $onehot0(m_axis_tdata[36:34])), "more than one compare flag set")

endmodule

bind time_of_day_arithmetic_unit tod_checker u_tod_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

[tb/testbench.sv]
// Self-checking testbench for the time-of-day arithmetic unit with stream ports.
`timescale 1ns / 100ps

module testbench;
    import tod_pkg::*;

    // Code 7 is not a command; the unit must answer it with an all-zero beat.
    localparam logic [2:0] CMD_UNUSED = 3'd7;

    localparam longint DAY_S  = 86400;
    localparam longint HOUR_S = 3600;
    localparam longint MIN_S  = 60;

    localparam int PIPE_DEPTH   = 9;       // beats in flight, plus slack when draining
    localparam int CYCLE_LIMIT  = 400000;  // slowest legal run is well under this
    localparam int RANDOM_ITEMS = 1300;

    typedef struct packed {
        logic [2:0]         command;
        logic [4:0]         hour_a;
        logic [5:0]         minute_a;
        logic [5:0]         second_a;
        logic [4:0]         hour_b;
        logic [5:0]         minute_b;
        logic [5:0]         second_b;
        logic signed [31:0] amount;
    } t_tod_item;

    typedef struct packed {
        logic        valid_res;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [16:0] seconds_total;
        logic        equal;
        logic        less;
        logic        greater;
    } t_tod_result;

    logic                    i_clk         = 1'b0;
    logic                    i_rst_n       = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    // hour_a, minute_a, second_a, hour_b, minute_b, second_b, amount, zero pad
    logic [IN_TDATA_W-1:0]   s_axis_tdata  = '0;
    // command
    logic [IN_TUSER_W-1:0]   s_axis_tuser  = '0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    // hour, minute, second, seconds_total, equal, less, greater, zero pad
    logic [OUT_TDATA_W-1:0]  m_axis_tdata;
    // valid_res
    logic [OUT_TUSER_W-1:0]  m_axis_tuser;

    t_tod_result tod_expected_q[$];
    int          mismatch_count  = 0;
    int          cycle_count     = 0;
    int          rx_hold_cycles  = 0;   // long receiver hold-off, set by the stall test
    int          rx_stall_left   = 0;
    bit          tx_steady       = 1'b0;
    bit          rx_steady       = 1'b0;

    time_of_day_arithmetic_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #6 i_clk = ~i_clk;

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles, %0d results outstanding", $time,
                     cycle_count, tod_expected_q.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ---------------------------------------------------------------- predictor

    // Reduce a signed second count onto the day and split it into H:M:S.
    function automatic t_tod_result wall_clock(input longint n);
        t_tod_result r;
        longint      t;
        r = '0;
        t = n % DAY_S;
        if (t < 0)
            t += DAY_S;
        r.valid_res     = 1'b1;
        r.hour          = 5'(t / HOUR_S);
        r.minute        = 6'((t % HOUR_S) / MIN_S);
        r.second        = 6'(t % MIN_S);
        r.seconds_total = 17'(t);
        return r;
    endfunction

    function automatic t_tod_result predict_tod(input t_tod_item it);
        t_tod_result r;
        logic        a_ok, b_ok;
        longint      ta, tb, amt, d;
        r    = '0;
        a_ok = it.hour_a <= MAX_HOUR && it.minute_a <= MAX_MINSEC && it.second_a <= MAX_MINSEC;
        b_ok = it.hour_b <= MAX_HOUR && it.minute_b <= MAX_MINSEC && it.second_b <= MAX_MINSEC;
        ta   = longint'(it.hour_a) * HOUR_S + longint'(it.minute_a) * MIN_S
               + longint'(it.second_a);
        tb   = longint'(it.hour_b) * HOUR_S + longint'(it.minute_b) * MIN_S
               + longint'(it.second_b);
        amt  = it.amount;   // sign-extends
        case (it.command)
            CMD_VALIDATE: r.valid_res = a_ok;
            CMD_TO_SECONDS: if (a_ok) begin
                r.valid_res     = 1'b1;
                r.seconds_total = 17'(ta);
            end
            CMD_FROM_SECONDS: r = wall_clock(amt);
            CMD_COMPARE: if (a_ok && b_ok) begin
                r.valid_res = 1'b1;
                r.equal     = ta == tb;
                r.less      = ta < tb;
                r.greater   = ta > tb;
            end
            CMD_ADD:      if (a_ok) r = wall_clock(ta + amt);
            CMD_SUBTRACT: if (a_ok) r = wall_clock(ta - amt);
            CMD_DURATION: if (a_ok && b_ok) begin
                d = tb - ta;
                if (ta > tb)
                    d += DAY_S;
                r.valid_res     = 1'b1;
                r.seconds_total = 17'(d);
            end
            default: ;  // unused code: everything stays zero
        endcase
        return r;
    endfunction

    // ---------------------------------------------------------------- stimulus helpers

    // Mostly back-to-back, sometimes a few cycles, now and then a long gap.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    function automatic t_tod_item make_item(input logic [2:0] cmd,
                                            input logic [4:0] ha, input logic [5:0] ma,
                                            input logic [5:0] sa, input logic [4:0] hb,
                                            input logic [5:0] mb, input logic [5:0] sb,
                                            input logic [31:0] amount);
        t_tod_item it;
        it.command  = cmd;
        it.hour_a   = ha;
        it.minute_a = ma;
        it.second_a = sa;
        it.hour_b   = hb;
        it.minute_b = mb;
        it.second_b = sb;
        it.amount   = amount;
        return it;
    endfunction

    function automatic logic [4:0] pick_hour();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return 5'd0;
        else if (r == 1)
            return MAX_HOUR;
        else if (r == 19)
            return 5'($urandom_range(24, 31));
        return 5'($urandom_range(0, 23));
    endfunction

    function automatic logic [5:0] pick_min_sec();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return 6'd0;
        else if (r == 1)
            return MAX_MINSEC;
        else if (r == 19)
            return 6'($urandom_range(60, 63));
        return 6'($urandom_range(0, 59));
    endfunction

    function automatic logic [31:0] pick_amount();
        case ($urandom_range(0, 5))
            0: return 32'($urandom_range(0, 200000)) - 32'd100000;
            1: return 32'($urandom);
            2: return 32'($urandom_range(0, 24000)) * 32'd86400 + 32'($urandom_range(0, 3))
                      - 32'd1;
            3: return 32'(0) - 32'($urandom_range(0, 24000)) * 32'd86400
                      + 32'($urandom_range(0, 2)) - 32'd1;
            4: case ($urandom_range(0, 3))
                   0: return 32'h7FFF_FFFF;
                   1: return 32'h8000_0000;
                   2: return 32'hFFFF_FFFF;
                   default: return 32'd0;
               endcase
            default: return 32'($urandom_range(0, 86399));
        endcase
    endfunction

    function automatic t_tod_item random_tod_item();
        t_tod_item it;
        it.command  = ($urandom_range(0, 99) < 3) ? CMD_UNUSED : 3'($urandom_range(0, 6));
        it.hour_a   = pick_hour();
        it.minute_a = pick_min_sec();
        it.second_a = pick_min_sec();
        if ($urandom_range(0, 4) == 0) begin
            // same time on both sides for equal compares and zero durations
            it.hour_b   = it.hour_a;
            it.minute_b = it.minute_a;
            it.second_b = it.second_a;
        end else begin
            it.hour_b   = pick_hour();
            it.minute_b = pick_min_sec();
            it.second_b = pick_min_sec();
        end
        it.amount = pick_amount();
        return it;
    endfunction

    // Drive one beat and wait for the handshake; the expectation is queued on accept.
    task automatic send_tod_item(input t_tod_item it);
        int gap;
        gap = tx_steady ? 0 : idle_len();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'b0, it.amount, it.second_b, it.minute_b, it.hour_b,
                          it.second_a, it.minute_a, it.hour_a};
        s_axis_tuser  <= it.command;
        do
            @(posedge i_clk);
        while (!s_axis_tready);
        tod_expected_q.push_back(predict_tod(it));
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (tod_expected_q.size() != 0)
            @(posedge i_clk);
        repeat (PIPE_DEPTH + 3) @(posedge i_clk);
    endtask

    // ---------------------------------------------------------------- receiver

    initial begin
        forever begin
            @(posedge i_clk);
            if (rx_hold_cycles > 0) begin
                m_axis_tready <= 1'b0;
                rx_hold_cycles = rx_hold_cycles - 1;
            end else if (rx_stall_left > 0) begin
                m_axis_tready <= 1'b0;
                rx_stall_left = rx_stall_left - 1;
            end else begin
                m_axis_tready <= 1'b1;
                rx_stall_left = rx_steady ? 0 : idle_len();
            end
        end
    end

    // ---------------------------------------------------------------- checker

    task automatic check_field(input string name, input longint unsigned want,
                               input longint unsigned got);
        if (want != got) begin
            mismatch_count++;
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_tod_result got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.valid_res     = m_axis_tuser[0];
            got.hour          = m_axis_tdata[4:0];
            got.minute        = m_axis_tdata[10:5];
            got.second        = m_axis_tdata[16:11];
            got.seconds_total = m_axis_tdata[33:17];
            got.equal         = m_axis_tdata[34];
            got.less          = m_axis_tdata[35];
            got.greater       = m_axis_tdata[36];
            if (tod_expected_q.size() == 0) begin
                mismatch_count++;
                $display("%0t: result beat with nothing expected: expected none, actual %h",
                         $time, got);
            end else begin
                want = tod_expected_q.pop_front();
                check_field("valid_res",     want.valid_res,     got.valid_res);
                check_field("hour",          want.hour,          got.hour);
                check_field("minute",        want.minute,        got.minute);
                check_field("second",        want.second,        got.second);
                check_field("seconds_total", want.seconds_total, got.seconds_total);
                check_field("equal",         want.equal,         got.equal);
                check_field("less",          want.less,          got.less);
                check_field("greater",       want.greater,       got.greater);
            end
        end
    end

    // ---------------------------------------------------------------- tests

    task automatic test_validate();
        send_tod_item(make_item(CMD_VALIDATE, 23, 59, 59, 0, 0, 0, 0));
        send_tod_item(make_item(CMD_VALIDATE, 24, 0, 0, 0, 0, 0, 0));
        send_tod_item(make_item(CMD_VALIDATE, 31, 63, 63, 31, 63, 63, 32'hFFFF_FFFF));
        send_tod_item(make_item(CMD_VALIDATE, 0, 60, 0, 0, 0, 0, 0));
        send_tod_item(make_item(CMD_VALIDATE, 0, 0, 60, 0, 0, 0, 0));
    endtask

    task automatic test_to_seconds();
        send_tod_item(make_item(CMD_TO_SECONDS, 23, 59, 59, 0, 0, 0, 0));
        send_tod_item(make_item(CMD_TO_SECONDS, 0, 0, 0, 31, 63, 63, 0));
        send_tod_item(make_item(CMD_TO_SECONDS, 24, 0, 0, 0, 0, 0, 0));
    endtask

    // Negative amounts lift into the day; both 32-bit extremes and a whole day.
    task automatic test_from_seconds();
        send_tod_item(make_item(CMD_FROM_SECONDS, 31, 63, 63, 0, 0, 0, 32'hFFFF_FFFF));
        send_tod_item(make_item(CMD_FROM_SECONDS, 0, 0, 0, 0, 0, 0, 32'h7FFF_FFFF));
        send_tod_item(make_item(CMD_FROM_SECONDS, 0, 0, 0, 0, 0, 0, 32'h8000_0000));
        send_tod_item(make_item(CMD_FROM_SECONDS, 0, 0, 0, 0, 0, 0, 32'd86400));
    endtask

    task automatic test_compare();
        send_tod_item(make_item(CMD_COMPARE, 12, 30, 15, 12, 30, 15, 0));
        send_tod_item(make_item(CMD_COMPARE, 0, 0, 0, 23, 59, 59, 0));
        send_tod_item(make_item(CMD_COMPARE, 23, 59, 59, 0, 0, 0, 0));
        send_tod_item(make_item(CMD_COMPARE, 1, 2, 3, 1, 60, 3, 0));  // B bad
    endtask

    // Wrap both ways over midnight, the most negative amount, and a bad A.
    task automatic test_add_subtract();
        send_tod_item(make_item(CMD_ADD, 23, 59, 59, 0, 0, 0, 32'd1));
        send_tod_item(make_item(CMD_SUBTRACT, 0, 0, 0, 0, 0, 0, 32'd1));
        send_tod_item(make_item(CMD_ADD, 23, 59, 59, 0, 0, 0, 32'h8000_0000));
        send_tod_item(make_item(CMD_SUBTRACT, 23, 59, 59, 0, 0, 0, 32'h8000_0000));
        send_tod_item(make_item(CMD_ADD, 25, 0, 0, 0, 0, 0, 32'd5));
    endtask

    task automatic test_duration();
        send_tod_item(make_item(CMD_DURATION, 23, 0, 0, 1, 0, 0, 0));    // crosses midnight
        send_tod_item(make_item(CMD_DURATION, 5, 6, 7, 5, 6, 7, 0));
        send_tod_item(make_item(CMD_DURATION, 0, 0, 0, 23, 59, 59, 0));
    endtask

    task automatic test_unused_command();
        send_tod_item(make_item(CMD_UNUSED, 1, 2, 3, 4, 5, 6, 32'd100));
    endtask

    // Receiver holds off long enough for the pipe to fill and push back on the input.
    task automatic test_backpressure();
        int n;
        tx_steady      = 1'b1;
        rx_hold_cycles = 150;
        for (n = 0; n < 40; n++)
            send_tod_item(random_tod_item());
        tx_steady = 1'b0;
        wait_drained();
    endtask

    // Random items in stretches; some stretches run with no idling on either side.
    task automatic test_random_mix();
        int sent, run, n;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            run       = $urandom_range(50, 150);
            tx_steady = $urandom_range(0, 3) == 0;
            rx_steady = $urandom_range(0, 3) == 0;
            for (n = 0; n < run && sent < RANDOM_ITEMS; n++) begin
                send_tod_item(random_tod_item());
                sent++;
            end
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
        wait_drained();
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_validate();
        test_to_seconds();
        test_from_seconds();
        test_compare();
        test_add_subtract();
        test_duration();
        test_unused_command();
        wait_drained();
        test_backpressure();
        test_random_mix();
        if (mismatch_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
